// ===== design/ccu_pkg.sv =====
// Shared types and constants for the cosine curve upsampler.
// No dependencies; every other design file imports this package.
`default_nettype none

package ccu_pkg;

    localparam int COORD_BITS     = 16;
    localparam int DATA_BITS      = 2 * COORD_BITS;
    localparam int WGT_FRAC       = 30;
    localparam int WGT_BITS       = WGT_FRAC + 1;
    localparam int PROD_BITS      = COORD_BITS + WGT_BITS;
    localparam int QUEUE_DEPTH    = 2;
    localparam int SMOOTH_DEFAULT = 16;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0]        mag_t;

    // One classified knot, ready for the back end to expand
    typedef struct packed {
        coord_t base_x;     // held knot, start of the segment
        coord_t base_y;
        coord_t knot_x;     // new knot, emitted when last_knot is set
        coord_t knot_y;
        mag_t   mag_x;      // |new - held|
        mag_t   mag_y;
        logic   neg_x;
        logic   neg_y;
        logic   interp;     // held knot present: emit it plus points between
        logic   last_knot;  // end of curve: emit the new knot too
        logic   cosine;     // cosine weights for y
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } q_push_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_head_t;

endpackage

`default_nettype wire

// ===== design/ccu_front.sv =====
// Front end: accepts knots, keeps the held knot and mode bit, and turns each knot
// after a held knot or at a curve end into a queue job. Depends on ccu_pkg.
`default_nettype none

module ccu_front
    import ccu_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DATA_BITS-1:0] s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    input  wire logic                 q_full,
    output q_push_t                   push
);

    logic   have_prev_reg, have_prev_next;
    coord_t prev_x_reg, prev_x_next;
    coord_t prev_y_reg, prev_y_next;
    logic   cosine_reg;

    logic   accept;
    coord_t knot_x, knot_y;
    logic signed [COORD_BITS:0] dx, dy, dx_abs, dy_abs;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign knot_x   = coord_t'(s_tdata[COORD_BITS-1:0]);
    assign knot_y   = coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);

    assign dx     = (COORD_BITS+1)'(knot_x) - (COORD_BITS+1)'(prev_x_reg);
    assign dy     = (COORD_BITS+1)'(knot_y) - (COORD_BITS+1)'(prev_y_reg);
    assign dx_abs = dx[COORD_BITS] ? -dx : dx;
    assign dy_abs = dy[COORD_BITS] ? -dy : dy;

    always_comb begin
        push.push          = accept && (have_prev_reg || s_tlast);
        push.job.base_x    = prev_x_reg;
        push.job.base_y    = prev_y_reg;
        push.job.knot_x    = knot_x;
        push.job.knot_y    = knot_y;
        push.job.mag_x     = dx_abs[COORD_BITS-1:0];
        push.job.mag_y     = dy_abs[COORD_BITS-1:0];
        push.job.neg_x     = dx[COORD_BITS];
        push.job.neg_y     = dy[COORD_BITS];
        push.job.interp    = have_prev_reg;
        push.job.last_knot = s_tlast;
        push.job.cosine    = cosine_reg;
    end

    always_comb begin
        have_prev_next = have_prev_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        if (accept) begin
            if (s_tlast) begin
                have_prev_next = 1'b0;
                prev_x_next    = '0;
                prev_y_next    = '0;
            end else begin
                have_prev_next = 1'b1;
                prev_x_next    = knot_x;
                prev_y_next    = knot_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            cosine_reg    <= 1'b1;
        end else begin
            have_prev_reg <= have_prev_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            if (cfg_wr_en) begin
                cosine_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/ccu_queue.sv =====
// Short job queue between the front and back ends.
// Depends on ccu_pkg for the job type.
`default_nettype none

module ccu_queue
    import ccu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire q_push_t push,
    input  wire logic    pop,
    output logic         full,
    output q_head_t      head
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    job_t                slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == CNT_BITS'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

`default_nettype wire

// ===== design/ccu_back.sv =====
// Back end: steps through each job, looks up blend weights, multiplies and
// rounds, and holds the result in the output register. Depends on ccu_pkg.
`default_nettype none

module ccu_back
    import ccu_pkg::*;
#(
    parameter int SMOOTH = SMOOTH_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire q_head_t              head,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [DATA_BITS-1:0]      m_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast
);

    localparam int STEP_BITS = $clog2(SMOOTH + 1);
    localparam int IDX_BITS  = $clog2(SMOOTH);
    localparam longint ONE_Q30 = longint'(1) << WGT_FRAC;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic [WGT_BITS-1:0] wtab_t [SMOOTH];

    function automatic longint clamp_q30(longint c);
        if (c < 0) return 0;
        if (c > ONE_Q30) return ONE_Q30;
        return c;
    endfunction

    // Cosine weight from a short Taylor series of cos(phi)
    function automatic longint cos_weight(int n);
        int m;
        logic flip;
        longint unsigned phi;
        longint p, c, w;
        m    = n;
        flip = 1'b0;
        if (2 * n > SMOOTH) begin
            m    = SMOOTH - n;
            flip = 1'b1;
        end
        phi = (PI_Q30 * longint'(m) + longint'(SMOOTH / 2)) / SMOOTH;
        p   = longint'((phi * phi) >> WGT_FRAC);
        c   = ONE_Q30;
        c   = clamp_q30(ONE_Q30 - (p * c / ONE_Q30) / 90);
        c   = clamp_q30(ONE_Q30 - (p * c / ONE_Q30) / 56);
        c   = clamp_q30(ONE_Q30 - (p * c / ONE_Q30) / 30);
        c   = clamp_q30(ONE_Q30 - (p * c / ONE_Q30) / 12);
        c   = clamp_q30(ONE_Q30 - (p * c / ONE_Q30) / 2);
        w   = (ONE_Q30 - c) / 2;
        return flip ? ONE_Q30 - w : w;
    endfunction

    function automatic wtab_t build_cos();
        wtab_t t;
        for (int n = 0; n < SMOOTH; n++) begin
            t[n] = WGT_BITS'(cos_weight(n));
        end
        return t;
    endfunction

    function automatic wtab_t build_lin();
        wtab_t t;
        for (int n = 0; n < SMOOTH; n++) begin
            t[n] = WGT_BITS'((longint'(n) * ONE_Q30 + longint'(SMOOTH / 2)) / SMOOTH);
        end
        return t;
    endfunction

    localparam wtab_t COS_TAB = build_cos();
    localparam wtab_t LIN_TAB = build_lin();

    logic enable;

    // step sequencer
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [IDX_BITS-1:0]  idx;
    logic                 in_segment;

    // stage 1: weights selected
    logic                s1_valid_reg;
    coord_t              s1_base_x_reg, s1_base_y_reg;
    mag_t                s1_mag_x_reg, s1_mag_y_reg;
    logic                s1_neg_x_reg, s1_neg_y_reg;
    logic [WGT_BITS-1:0] s1_wx_reg, s1_wy_reg;
    logic                s1_knot_reg, s1_last_reg;

    coord_t              g_base_x, g_base_y;
    mag_t                g_mag_x, g_mag_y;
    logic                g_neg_x, g_neg_y;
    logic [WGT_BITS-1:0] g_wx, g_wy;
    logic                g_knot, g_last;

    // stage 2: products
    logic                 s2_valid_reg;
    logic [PROD_BITS-1:0] s2_prod_x_reg, s2_prod_y_reg;
    coord_t               s2_base_x_reg, s2_base_y_reg;
    logic                 s2_neg_x_reg, s2_neg_y_reg;
    logic                 s2_knot_reg, s2_last_reg;

    // stage 3: round and offset
    logic [PROD_BITS:0]  sum_x, sum_y;
    mag_t                r_x, r_y;
    coord_t              pt_x, pt_y;

    logic                m_tvalid_reg;
    coord_t              m_x_reg, m_y_reg;
    logic                m_knot_reg, m_last_reg;

    assign enable = !m_tvalid_reg || m_tready;

    assign idx        = step_reg[IDX_BITS-1:0];
    assign in_segment = head.job.interp && (step_reg < STEP_BITS'(SMOOTH));

    always_comb begin
        if (in_segment) begin
            g_base_x = head.job.base_x;
            g_base_y = head.job.base_y;
            g_mag_x  = head.job.mag_x;
            g_mag_y  = head.job.mag_y;
            g_neg_x  = head.job.neg_x;
            g_neg_y  = head.job.neg_y;
            // weight at step zero is zero: the held knot comes out unchanged
            g_wx     = LIN_TAB[idx];
            g_wy     = head.job.cosine ? COS_TAB[idx] : LIN_TAB[idx];
            g_knot   = (step_reg == '0);
            g_last   = (step_reg == STEP_BITS'(SMOOTH - 1)) && !head.job.last_knot;
        end else begin
            // closing knot of the curve
            g_base_x = head.job.knot_x;
            g_base_y = head.job.knot_y;
            g_mag_x  = '0;
            g_mag_y  = '0;
            g_neg_x  = 1'b0;
            g_neg_y  = 1'b0;
            g_wx     = '0;
            g_wy     = '0;
            g_knot   = 1'b1;
            g_last   = 1'b1;
        end
    end

    assign pop = enable && head.valid && g_last;

    always_comb begin
        step_next = step_reg;
        if (enable && head.valid) begin
            step_next = g_last ? '0 : step_reg + 1'b1;
        end
    end

    assign sum_x = (PROD_BITS+1)'(s2_prod_x_reg) + ((PROD_BITS+1)'(1) << (WGT_FRAC - 1));
    assign sum_y = (PROD_BITS+1)'(s2_prod_y_reg) + ((PROD_BITS+1)'(1) << (WGT_FRAC - 1));
    assign r_x   = sum_x[WGT_FRAC +: COORD_BITS];
    assign r_y   = sum_y[WGT_FRAC +: COORD_BITS];
    assign pt_x  = s2_neg_x_reg ? s2_base_x_reg - coord_t'(r_x) : s2_base_x_reg + coord_t'(r_x);
    assign pt_y  = s2_neg_y_reg ? s2_base_y_reg - coord_t'(r_y) : s2_base_y_reg + coord_t'(r_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (enable) begin
                s1_valid_reg <= head.valid;
                s2_valid_reg <= s1_valid_reg;
                m_tvalid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            s1_base_x_reg <= g_base_x;
            s1_base_y_reg <= g_base_y;
            s1_mag_x_reg  <= g_mag_x;
            s1_mag_y_reg  <= g_mag_y;
            s1_neg_x_reg  <= g_neg_x;
            s1_neg_y_reg  <= g_neg_y;
            s1_wx_reg     <= g_wx;
            s1_wy_reg     <= g_wy;
            s1_knot_reg   <= g_knot;
            s1_last_reg   <= g_last;

            s2_prod_x_reg <= PROD_BITS'(s1_mag_x_reg) * PROD_BITS'(s1_wx_reg);
            s2_prod_y_reg <= PROD_BITS'(s1_mag_y_reg) * PROD_BITS'(s1_wy_reg);
            s2_base_x_reg <= s1_base_x_reg;
            s2_base_y_reg <= s1_base_y_reg;
            s2_neg_x_reg  <= s1_neg_x_reg;
            s2_neg_y_reg  <= s1_neg_y_reg;
            s2_knot_reg   <= s1_knot_reg;
            s2_last_reg   <= s1_last_reg;

            m_x_reg    <= pt_x;
            m_y_reg    <= pt_y;
            m_knot_reg <= s2_knot_reg;
            m_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_y_reg, m_x_reg};
    assign m_tuser  = m_knot_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== design/cosine_curve_upsampler.sv =====
// Cosine curve upsampler, top level: front end, job queue and back end.
// Depends on ccu_pkg, ccu_front, ccu_queue and ccu_back.
//
// Usage:
//   Knots enter on the s_ stream, one per item: tdata carries x (low half)
//   and y (high half), tlast marks the end of a curve. Results leave on the
//   m_ stream: tdata is x (low) and y (high), tuser is 1 for an original
//   knot, tlast marks the final result caused by one input item.
//   A knot following a held knot yields the held knot plus SMOOTH-1 points
//   between the two, plus the new knot itself when it ends the curve.
//   cfg_wr_en writes cfg_wr_data into the cosine-mode bit (1 = cosine blend
//   of y, 0 = linear); write it only while the block is idle.
// Timing:
//   A knot, once accepted, goes through the job queue, then the stage 1,
//   stage 2 and output registers of the back end. Results leave at one per
//   cycle while m_tready is high. Two knots can wait in the job queue, so
//   the input keeps flowing while results are drained.
// Reset:
//   aresetn low clears the held knot, empties the queue and pipeline and sets
//   cosine mode. When m_tready is low the output item holds and the back end
//   stalls; the front end keeps accepting until the queue fills.
`default_nettype none

module cosine_curve_upsampler
    import ccu_pkg::*;
#(
    parameter int SMOOTH = SMOOTH_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,    // use_cosine
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DATA_BITS-1:0] s_tdata,        // knot_x, knot_y
    input  wire logic                 s_tlast,        // end_of_curve
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [DATA_BITS-1:0]      m_tdata,        // point_x, point_y
    output logic                      m_tuser,        // is_knot
    output logic                      m_tlast         // last_of_run
);

    q_push_t push;
    q_head_t head;
    logic    q_full;
    logic    pop;

    ccu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .push        (push)
    );

    ccu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .full    (q_full),
        .head    (head)
    );

    ccu_back #(
        .SMOOTH (SMOOTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== design/ccu_checker.sv =====
// Port-level checks for the cosine curve upsampler, bound to the top level.
// Depends on ccu_pkg and cosine_curve_upsampler.
`default_nettype none

module ccu_checker
    import ccu_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [DATA_BITS-1:0] m_tdata,
    input wire logic                 m_tuser,
    input wire logic                 m_tlast
);

    // reset flushes the output stage
    a_reset_flush: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output item valid right after reset");

    // reset empties the job queue, so input is open again
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    // a stalled output item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output item changed while stalled");

endmodule

bind cosine_curve_upsampler ccu_checker u_ccu_checker (.*);

`default_nettype wire
